>>> sv/fp32a_pkg.sv
package fp32a_pkg;
  localparam int FracBits = 23;
  localparam int ExpBits  = 8;
  localparam int SigBits  = FracBits + 1;
  localparam int SumBits  = SigBits + 1;
  localparam int PosBits  = 5;

  typedef logic [ExpBits-1:0] exp_t;
  typedef logic [SigBits-1:0] sig_t;
  typedef logic [SumBits-1:0] mag_t;

  // position of the highest set bit, magnitude known nonzero
  function automatic logic [PosBits-1:0] lead_one(input mag_t m);
    logic [PosBits-1:0] p;
    p = '0;
    for (int i = 0; i < SumBits; i++) begin
      if (m[i]) p = PosBits'(i);
    end
    return p;
  endfunction
endpackage

>>> sv/fp32a_norm.sv
module fp32a_norm
  import fp32a_pkg::*;
(
  input  mag_t                mag,
  input  logic [PosBits-1:0]  pos,
  output logic [FracBits-1:0] frac
);
  mag_t sh;

  // magnitude is at most 25 bits, so only bit 24 ever needs a right shift
  always_comb begin
    if (pos > PosBits'(FracBits)) sh = mag >> 1;
    else sh = mag << (PosBits'(FracBits) - pos);
    frac = sh[FracBits-1:0];
  end
endmodule

>>> sv/fp32_truncating_adder.sv
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | operand_a [31:0], operand_b [63:32]
// m_axis  | out | sum_bits [31:0]
// four register stages: align, add, leading-one count, normalize
// one transfer per cycle sustained while m_axis_tready stays high
// rst clears the stage valid bits only
// a stall holds every full stage in place; a bubble is filled as items advance
module fp32_truncating_adder
  import fp32a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // sum_bits
);
  logic [3:0] vld;
  logic [3:0] adv;

  exp_t big1, big2, big3;
  sig_t sa1, sb1;
  logic na1, nb1;
  logic [SumBits:0] sum2;
  mag_t mag3;
  logic sign3, zero3;
  logic [PosBits-1:0] pos3;
  logic [31:0] res4;

  assign adv[3] = !vld[3] || m_axis_tready;
  assign adv[2] = !vld[2] || adv[3];
  assign adv[1] = !vld[1] || adv[2];
  assign adv[0] = !vld[0] || adv[1];
  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[3];
  assign m_axis_tdata  = res4;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else begin
      if (adv[0]) vld[0] <= s_axis_tvalid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  logic [31:0] a, b;
  exp_t ea, eb, bg, da, db;
  sig_t ga, gb;
  assign a  = s_axis_tdata[31:0];
  assign b  = s_axis_tdata[63:32];
  assign ea = a[30:23];
  assign eb = b[30:23];
  assign bg = (ea > eb) ? ea : eb;
  assign da = bg - ea;
  assign db = bg - eb;
  assign ga = (da >= ExpBits'(SigBits)) ? '0 : ({1'b1, a[22:0]} >> da);
  assign gb = (db >= ExpBits'(SigBits)) ? '0 : ({1'b1, b[22:0]} >> db);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      big1 <= bg; sa1 <= ga; sb1 <= gb; na1 <= a[31]; nb1 <= b[31];
    end
  end

  logic [SumBits:0] xa, xb;
  assign xa = na1 ? -{2'b0, sa1} : {2'b0, sa1};
  assign xb = nb1 ? -{2'b0, sb1} : {2'b0, sb1};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sum2 <= xa + xb; big2 <= big1;
    end
  end

  logic [SumBits:0] abs2;
  assign abs2 = sum2[SumBits] ? -sum2 : sum2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      mag3  <= abs2[SumBits-1:0];
      sign3 <= sum2[SumBits];
      zero3 <= (sum2 == '0);
      pos3  <= lead_one(abs2[SumBits-1:0]);
      big3  <= big2;
    end
  end

  logic [FracBits-1:0] frac3;
  exp_t exp3;
  fp32a_norm u_norm (.mag(mag3), .pos(pos3), .frac(frac3));
  // exponent wraps modulo 256
  assign exp3 = big3 + ExpBits'(pos3) - ExpBits'(FracBits);

  always_ff @(posedge clk) begin
    if (adv[3]) res4 <= zero3 ? '0 : {sign3, exp3, frac3};
  end
endmodule

>>> sv/fp32a_check.sv
module fp32a_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with output free");
endmodule

bind fp32_truncating_adder fp32a_check u_check (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps

class sum_scoreboard;
  logic [31:0] sums_due[$];
  int errors;

  // truncating single-precision sum of two bit patterns
  function automatic logic [31:0] trunc_sum(logic [31:0] a, logic [31:0] b);
    logic [7:0] ea, eb, big;
    logic signed [31:0] va, vb, total;
    logic [31:0] mag;
    logic sgn;
    int p, da, db;
    ea = a[30:23];
    eb = b[30:23];
    big = (ea > eb) ? ea : eb;
    da = int'(big - ea);
    db = int'(big - eb);
    va = (da >= 32) ? 0 : ({8'd0, 1'b1, a[22:0]} >> da);
    vb = (db >= 32) ? 0 : ({8'd0, 1'b1, b[22:0]} >> db);
    if (a[31]) va = -va;
    if (b[31]) vb = -vb;
    total = va + vb;
    if (total == 0) return 32'd0;
    sgn = total < 0;
    mag = sgn ? -total : total;
    p = 31;
    while (!mag[p]) p--;
    if (p > 23) mag = mag >> (p - 23);
    else mag = mag << (23 - p);
    return {sgn, 8'(big + p - 23), mag[22:0]};
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function void note_operands(logic [31:0] a, logic [31:0] b);
    sums_due.push_back(trunc_sum(a, b));
  endfunction

  task check_sum(logic [31:0] got);
    logic [31:0] want;
    if (sums_due.size() == 0) begin
      report($sformatf("sum %h with nothing outstanding", got));
      return;
    end
    want = sums_due.pop_front();
    if (got !== want) report($sformatf("sum_bits got %h want %h", got, want));
  endtask
endclass

module tb;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // operand_a, operand_b
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;       // sum_bits

  sum_scoreboard sb = new();
  bit hold_rx = 0;
  bit rx_gaps = 1;
  int quiet = 0;

  fp32_truncating_adder DUT (.*);

  always #5 clk = ~clk;

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("FAIL fp32_truncating_adder");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_sum(m_axis_tdata);
  end

  // receiver: random stalls per result
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      w = rx_gaps ? $urandom_range(0, 13) : 0;
      if (w > 0 || hold_rx) begin
        m_axis_tready <= 0;
        repeat (w) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk iff m_axis_tvalid);
    end
  end

  task automatic send_pair(logic [31:0] a, logic [31:0] b, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {b, a};
    @(posedge clk iff s_axis_tready);
    sb.note_operands(a, b);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (sb.sums_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 3))
      0: x[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
      1: x[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'd255;
      default: ;
    endcase
    return x;
  endfunction

  initial begin
    logic [31:0] a, b;
    int gap;
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed corners
    send_pair(32'h3f800000, 32'h3f800000, 0);
    send_pair(32'h3f800000, 32'hbf800000, 0);  // exact cancel
    send_pair(32'h00000000, 32'h80000000, 0);
    send_pair(32'h7fffffff, 32'h7fffffff, 0);  // exponent wrap up
    send_pair(32'hffffffff, 32'h7fffffff, 0);
    send_pair(32'h3f800000, 32'h33800000, 0);  // gap 24
    send_pair(32'h3f800000, 32'h34000000, 0);  // gap 23
    send_pair(32'h3f800000, 32'h00000000, 0);  // gap beyond 32
    send_pair(32'h3fffffff, 32'hbfffffff, 0);
    send_pair(32'h3f800001, 32'hbf800000, 0);  // deep normalize
    send_pair(32'h00000000, 32'h80000001, 0);  // exponent wrap down
    send_pair(32'h80c00000, 32'h00800000, 0);  // negative, exponent and fraction zero
    send_pair(32'h7f800000, 32'hff800000, 0);
    send_pair(32'hc0400000, 32'h3f000000, 0);
    send_pair(32'hffffffff, 32'hffffffff, 0);
    drain();
    // long receiver hold while sender keeps offering
    hold_rx = 1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_rx = 0;
      end
      for (int i = 0; i < 20; i++) send_pair(rand_operand(), rand_operand(), 0);
    join
    drain();
    for (int i = 0; i < 1150; i++) begin
      if (i == 400) rx_gaps = 0;
      if (i == 600) rx_gaps = 1;
      a = rand_operand();
      b = rand_operand();
      if ($urandom_range(0, 4) == 0) b[30:23] = a[30:23];
      if ($urandom_range(0, 9) == 0) b = {~a[31], a[30:0]};
      gap = (i >= 200 && i < 500) ? 0 : $urandom_range(0, 13);
      send_pair(a, b, gap);
    end
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.sums_due.size() == 0) $display("PASS fp32_truncating_adder");
    else $display("FAIL fp32_truncating_adder");
    $finish;
  end
endmodule
